// ===== hw/rtl/lzsswd_pkg.sv =====
// Shared types and constants for the LZSS window decompressor.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package lzsswd_pkg;

   localparam int unsigned WIN_DEPTH = 4096;
   localparam int unsigned WIN_AW    = 12;

   // write position at the start of every stream
   localparam logic [WIN_AW-1:0] START_POS = 12'hFEE;

   localparam logic [4:0] MIN_MATCH   = 5'd3;
   localparam logic [3:0] FLAG_BITS   = 4'd8;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_TOKEN,
      PH_MATCH
   } phase_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY,
      ST_FLUSH
   } state_type;

   // one byte handed to the emit stage
   typedef struct packed {
      logic       valid;
      logic       lit;
      logic [7:0] lit_byte;
      logic       bypass;
      logic [7:0] bypass_byte;
      logic       last;
   } load_type;

   // emit stage status back to the controller
   typedef struct packed {
      logic       slot_free;
      logic       busy;
      logic       wr_en;
      logic [7:0] wr_byte;
   } emit_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lzsswd_window.sv =====
// 4096 x 8 history window: one write port, one read port, registered read data.
// Depends on lzsswd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzsswd_window
   import lzsswd_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [WIN_AW-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [WIN_AW-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [WIN_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read-first; same-address collisions are forwarded by the controller
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lzsswd_emit.sv =====
// Emit stage: holds the byte whose window read is in flight, then the output register.
// Depends on lzsswd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzsswd_emit
   import lzsswd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  load_type        load,
   input  logic [7:0]      mem_q,
   output emit_status_type status,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast    // last_of_run
);

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_lit_ff;
   logic [7:0] s1_lit_byte_ff;
   logic       s1_bypass_ff;
   logic [7:0] s1_bypass_byte_ff;
   logic       s1_last_ff;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic [7:0] s1_byte;
   logic       out_free;
   logic       s1_go;

   always_comb begin
      priority if (s1_lit_ff) begin
         s1_byte = s1_lit_byte_ff;
      end else if (s1_bypass_ff) begin
         s1_byte = s1_bypass_byte_ff;
      end else begin
         s1_byte = mem_q;
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign s1_go    = s1_valid_ff && out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (load.valid) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.valid) begin
         s1_lit_ff         <= load.lit;
         s1_lit_byte_ff    <= load.lit_byte;
         s1_bypass_ff      <= load.bypass;
         s1_bypass_byte_ff <= load.bypass_byte;
         s1_last_ff        <= load.last;
      end
      if (s1_go) begin
         out_byte_ff <= s1_byte;
         out_last_ff <= s1_last_ff;
      end
   end

   assign status.slot_free = !s1_valid_ff || s1_go;
   assign status.busy      = s1_valid_ff;
   assign status.wr_en     = s1_go;
   assign status.wr_byte   = s1_byte;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lzsswd_ctrl.sv =====
// Token parser and copy sequencer: drives the window ports and feeds the emit stage.
// Depends on lzsswd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzsswd_ctrl
   import lzsswd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   input  emit_status_type   status,
   output load_type          load,
   output logic              wr_en,
   output logic [WIN_AW-1:0] wr_addr,
   output logic [7:0]        wr_data,
   output logic              rd_en,
   output logic [WIN_AW-1:0] rd_addr
);

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in, phase_eff;
   logic [7:0]        bits_ff, bits_in;
   logic [3:0]        left_ff, left_in, left_dec;
   logic [7:0]        off_low_ff, off_low_in;
   logic [WIN_AW-1:0] wpos_ff, wpos_in;
   logic [WIN_AW-1:0] rd_addr_ff, rd_addr_in;
   logic [4:0]        rem_ff, rem_in;
   logic              eos_ff, eos_in;
   logic [WIN_AW-1:0] clr_addr_ff, clr_addr_in;

   logic accept;
   logic is_lit;
   logic is_match;
   logic issue;
   logic clearing;
   logic clear_start;

   // a token phase with no flag bits left takes the byte as a new flag byte
   always_comb begin
      if (phase_ff == PH_TOKEN && left_ff == 4'd0) begin
         phase_eff = PH_FLAG;
      end else begin
         phase_eff = phase_ff;
      end
   end

   assign req_tready  = (state_ff == ST_IDLE) && status.slot_free;
   assign accept      = req_tvalid && req_tready;
   assign is_lit      = accept && phase_eff == PH_TOKEN && bits_ff[0];
   assign is_match    = accept && phase_eff == PH_MATCH;
   assign issue       = (state_ff == ST_COPY) && status.slot_free;
   assign clearing    = (state_ff == ST_CLEAR);
   assign clear_start = (state_ff == ST_FLUSH) && !status.busy;
   assign left_dec    = (left_ff == 4'd0) ? 4'd0 : left_ff - 4'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == WIN_AW'(WIN_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            priority if (is_match) begin
               state_in = ST_COPY;
            end else if (accept && req_tlast) begin
               state_in = ST_FLUSH;
            end
         end
         ST_COPY: begin
            if (issue && rem_ff == 5'd1) begin
               state_in = eos_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (!status.busy) begin
               state_in = ST_CLEAR;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      load.valid       = is_lit || issue;
      load.lit         = is_lit;
      load.lit_byte    = req_tdata;
      // read of the entry written in this very cycle
      load.bypass      = status.wr_en && (rd_addr_ff == wpos_ff);
      load.bypass_byte = status.wr_byte;
      load.last        = is_lit || (rem_ff == 5'd1);
      rd_en            = issue;
      rd_addr          = rd_addr_ff;
      wr_en            = clearing || status.wr_en;
      wr_addr          = clearing ? clr_addr_ff : wpos_ff;
      wr_data          = clearing ? 8'd0 : status.wr_byte;
   end

   // parser and sequencer registers
   always_comb begin
      phase_in    = phase_ff;
      bits_in     = bits_ff;
      left_in     = left_ff;
      off_low_in  = off_low_ff;
      rd_addr_in  = rd_addr_ff;
      rem_in      = rem_ff;
      eos_in      = eos_ff;
      wpos_in     = wpos_ff + WIN_AW'(status.wr_en);
      clr_addr_in = clearing ? clr_addr_ff + WIN_AW'(1) : clr_addr_ff;

      if (accept) begin
         unique case (phase_eff)
            PH_TOKEN: begin
               if (bits_ff[0]) begin
                  bits_in  = {1'b0, bits_ff[7:1]};
                  left_in  = left_dec;
                  phase_in = (left_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
               end else begin
                  off_low_in = req_tdata;
                  phase_in   = PH_MATCH;
               end
            end
            PH_MATCH: begin
               rd_addr_in = {req_tdata[7:4], off_low_ff};
               rem_in     = {1'b0, req_tdata[3:0]} + MIN_MATCH;
               bits_in    = {1'b0, bits_ff[7:1]};
               left_in    = left_dec;
               phase_in   = (left_dec == 4'd0) ? PH_FLAG : PH_TOKEN;
            end
            default: begin
               bits_in  = req_tdata;
               left_in  = FLAG_BITS;
               phase_in = PH_TOKEN;
            end
         endcase
         if (req_tlast) begin
            bits_in  = 8'd0;
            left_in  = 4'd0;
            phase_in = PH_FLAG;
            eos_in   = 1'b1;
         end
      end

      if (issue) begin
         rd_addr_in = rd_addr_ff + WIN_AW'(1);
         rem_in     = rem_ff - 5'd1;
      end

      if (clear_start) begin
         wpos_in     = START_POS;
         clr_addr_in = '0;
         eos_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         phase_ff    <= PH_FLAG;
         bits_ff     <= 8'd0;
         left_ff     <= 4'd0;
         wpos_ff     <= START_POS;
         rem_ff      <= 5'd0;
         eos_ff      <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         bits_ff     <= bits_in;
         left_ff     <= left_in;
         wpos_ff     <= wpos_in;
         rem_ff      <= rem_in;
         eos_ff      <= eos_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      off_low_ff <= off_low_in;
      rd_addr_ff <= rd_addr_in;
   end

   a_copy_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY |-> rem_ff != 5'd0)
      else $error("copy running with no bytes left");

   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !status.busy && !status.wr_en && wpos_ff == START_POS)
      else $error("window clear overlaps emitted bytes");

   a_eos_flush: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast && !is_match |=> state_ff == ST_FLUSH)
      else $error("end of stream did not start a flush");

   a_match_start: assert property (@(posedge clock) disable iff (reset)
      is_match |=> state_ff == ST_COPY && rem_ff >= MIN_MATCH)
      else $error("match item did not start a copy");

endmodule

`default_nettype wire

// ===== hw/rtl/lzss_window_decompressor.sv =====
// Channel   Dir  tdata             tlast            tuser
// req_      in   [7:0] in_byte     end_of_stream    -
// rsp_      out  [7:0] out_byte    last_of_run      -
//
// A flag byte, literal or first match byte starts no copy. The second match byte starts
// a copy of 3 to 18 bytes, one output byte per cycle through the single window read port
// while the rsp_ side does not stall; no item is taken until the copy is done.
// After reset and after every end-of-stream item the window is zeroed by a clearing
// pass over all 4096 entries; no item is taken meanwhile.
// A stalled rsp_ side holds the copy; reads resume when the output register drains.
// Top level of the LZSS decompressor; depends on lzsswd_pkg, lzsswd_ctrl,
// lzsswd_window and lzsswd_emit.
`timescale 1ns / 1ps
`default_nettype none

module lzss_window_decompressor
   import lzsswd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // last_of_run
);

   emit_status_type   status;
   load_type          load;
   logic              wr_en;
   logic [WIN_AW-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [WIN_AW-1:0] rd_addr;
   logic [7:0]        rd_data;

   lzsswd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .status     (status),
      .load       (load),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   lzsswd_window u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lzsswd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .mem_q      (rd_data),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for lzss_window_decompressor: streams compressed bytes in,
// predicts each decoded byte and checks it on the rsp_ side.
// Depends on lzsswd_pkg and the lzss_window_decompressor RTL.
`timescale 1ns / 1ps

module testbench;
   import lzsswd_pkg::*;

   // one decoded byte as the bench expects it
   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } decoded_type;

   class decomp_scoreboard;
      logic [7:0]    window [WIN_DEPTH];
      logic [11:0]   wr_pos;
      logic [7:0]    flags;
      logic [3:0]    bits_left;
      phase_type     phase;
      logic [7:0]    offset_low;
      decoded_type   expected_q [$];
      int            failures;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         foreach (window[i]) window[i] = '0;
         wr_pos     = START_POS;
         flags      = '0;
         bits_left  = '0;
         phase      = PH_FLAG;
         offset_low = '0;
      endfunction

      function void put(logic [7:0] value);
         decoded_type d;
         d.last = 1'b0;
         d.data = value;
         expected_q = {expected_q, d};
         window[wr_pos] = value;
         wr_pos = wr_pos + 1'b1;
      endfunction

      function void take_bit();
         flags = flags >> 1;
         if (bits_left != 0) bits_left = bits_left - 1'b1;
         phase = (bits_left == 0) ? PH_FLAG : PH_TOKEN;
      endfunction

      // expand one accepted compressed byte into its decoded bytes
      function void note_compressed(logic [7:0] b, logic eos);
         logic [11:0] rd;
         logic [4:0]  len;
         int          first;
         decoded_type tail;
         first = expected_q.size();
         if (phase == PH_TOKEN && bits_left == 0) phase = PH_FLAG;
         case (phase)
            PH_TOKEN: begin
               if (flags[0]) begin
                  put(b);
                  take_bit();
               end else begin
                  offset_low = b;
                  phase = PH_MATCH;
               end
            end
            PH_MATCH: begin
               rd  = {b[7:4], offset_low};
               len = {1'b0, b[3:0]} + MIN_MATCH;
               // byte by byte, so an overlapping copy sees what it just wrote
               for (int i = 0; i < len; i++) begin
                  put(window[rd]);
                  rd = rd + 1'b1;
               end
               take_bit();
            end
            default: begin
               flags     = b;
               bits_left = FLAG_BITS;
               phase     = PH_TOKEN;
            end
         endcase
         if (expected_q.size() > first) begin
            tail = expected_q[expected_q.size() - 1];
            tail.last = 1'b1;
            expected_q[expected_q.size() - 1] = tail;
         end
         if (eos) restart();
      endfunction

      function void check_decoded(logic [7:0] data, logic last);
         decoded_type want;
         if (expected_q.size() == 0) begin
            failures++;
            $display("%0t: unexpected item out_byte %02h last_of_run %0b", $time, data, last);
            return;
         end
         want = expected_q.pop_front();
         if (data !== want.data) begin
            failures++;
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
         end
         if (last !== want.last) begin
            failures++;
            $display("%0t: last_of_run expected %0b actual %0b", $time, want.last, last);
         end
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   decomp_scoreboard sb = new();

   int         gap_pct = 0;
   int         stall_pct = 0;
   int         items_sent = 0;
   logic [7:0] stream_bytes [$];

   // {end_of_stream, in_byte}
   localparam logic [8:0] DIRECTED_ITEMS [24] = '{
      // eight literals at the extremes, then matches: plain, long overlapping, wrapped,
      // and a stream cut after the first match byte
      9'h0FF, 9'h000, 9'h0FF, 9'h055, 9'h0AA, 9'h001, 9'h080, 9'h07F, 9'h0FE,
      9'h000, 9'h0EE, 9'h0F0, 9'h0F8, 9'h0FF, 9'h000, 9'h000, 9'h112,
      // stream cut on its flag byte
      9'h1A5,
      // fresh window: literal then a run copied over itself, ends on the match
      9'h001, 9'h03C, 9'h0EE, 9'h1F2,
      // stream ending on a literal
      9'h001, 9'h1C3
   };

   localparam int GAP_TAB [4]   = '{0, 75, 0, 18};
   localparam int STALL_TAB [4] = '{0, 0, 75, 18};

   lzss_window_decompressor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_decoded(rsp_tdata, rsp_tlast);
   end

   // entered at a falling edge, returns at a falling edge with tvalid still high
   task automatic send_item(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      sb.note_compressed(b, eos);
      items_sent++;
      @(negedge clock);
   endtask

   // well-formed token stream with random content, sometimes cut short or pure noise
   task automatic build_stream();
      int          n_tokens;
      int          left;
      int          len;
      int          cut;
      logic [7:0]  flag_byte;
      logic [11:0] wpos;
      logic [11:0] src;
      stream_bytes.delete();
      if ($urandom_range(7) == 0) begin
         repeat ($urandom_range(1, 12)) stream_bytes = {stream_bytes, 8'($urandom_range(255))};
         return;
      end
      wpos = START_POS;
      left = 0;
      flag_byte = '0;
      n_tokens = $urandom_range(1, 24);
      repeat (n_tokens) begin
         if (left == 0) begin
            flag_byte = 8'($urandom_range(255));
            stream_bytes = {stream_bytes, flag_byte};
            left = 8;
         end
         if (flag_byte[0]) begin
            stream_bytes = {stream_bytes, 8'($urandom_range(255))};
            wpos = wpos + 1'b1;
         end else begin
            len = $urandom_range(0, 15);
            case ($urandom_range(3))
               0:       src = 12'($urandom_range(4095));
               1:       src = wpos - 12'($urandom_range(1, len + 3));
               default: src = wpos - 12'($urandom_range(1, 64));
            endcase
            stream_bytes = {stream_bytes, src[7:0]};
            stream_bytes = {stream_bytes, {src[11:8], len[3:0]}};
            wpos = wpos + len[11:0] + 12'd3;
         end
         flag_byte = flag_byte >> 1;
         left--;
      end
      if ($urandom_range(4) == 0) begin
         cut = $urandom_range(1, stream_bytes.size());
         while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
      end
   endtask

   initial begin
      int quota;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_ITEMS[i]) send_item(DIRECTED_ITEMS[i][7:0], DIRECTED_ITEMS[i][8]);
      for (int ph = 0; ph < 4; ph++) begin
         gap_pct   = GAP_TAB[ph];
         stall_pct = STALL_TAB[ph];
         quota = items_sent + 15;
         while (items_sent < quota) begin
            build_stream();
            foreach (stream_bytes[i]) send_item(stream_bytes[i], i == stream_bytes.size() - 1);
         end
         // hold off until the block has drained
         req_tvalid <= 1'b0;
         do @(negedge clock); while (sb.outstanding() != 0);
      end
      repeat (40) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
